FILE: sv/random_sample_multiset_defines.svh
// Assertion macros for the multiset block.
`ifndef RANDOM_SAMPLE_MULTISET_DEFINES_SVH
`define RANDOM_SAMPLE_MULTISET_DEFINES_SVH

`ifndef SYNTHESIS
`define RSM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSM_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RSM_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

FILE: sv/rsm_pkg.sv
package rsm_pkg;

  localparam int KIND_W = 2;
  localparam int VAL_W = 32;
  localparam int RND_W = 31;
  localparam int ST_W = 2;
  localparam int DIV_CNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(RND_W);

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic wr_tail;
    logic cnt_inc;
    logic rd_last;
    logic wr_pos;
    logic cnt_dec;
    logic div_start;
    logic div_step;
    logic rd_rem;
    logic cap_data;
    logic set_flag;
    logic set_full;
    logic set_empty;
    logic res_load;
  } rsm_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic full;
    logic empty;
    logic match;
    logic scan_end;
    logic div_done;
    logic out_free;
  } rsm_sts_t;

endpackage

FILE: sv/random_sample_multiset.sv
// Channel   Dir  tdata (lowest bit up)                      tuser
// in_       in   value[31:0], random_word[62:32], pad 0    kind[1:0]
// out_      out  answer_flag[0], sampled_value[32:1], pad 0 status[1:0]
//
// One item is in work at a time. Insert and remove scan the stored entries through
// the single read port of the store, one entry per cycle. A sample runs a 31-step
// restoring remainder by the count.
// After reset the store is empty and no clearing pass is needed.
// A new item is taken while a finished result still waits in the output register.
`include "random_sample_multiset_defines.svh"

module random_sample_multiset #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // value[31:0], random_word[62:32]
  input  logic [1:0]  in_tuser,  // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // answer_flag[0], sampled_value[32:1]
  output logic [1:0]  out_tuser  // status[1:0]
);

  import rsm_pkg::*;

  rsm_cmd_t          cmd;
  rsm_sts_t          sts;
  logic              res_flag;
  logic [VAL_W-1:0]  res_value;
  logic [ST_W-1:0]   res_status;

  rsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsm_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_tuser[KIND_W-1:0]),
    .in_value         (in_tdata[VAL_W-1:0]),
    .in_random_word   (in_tdata[VAL_W+RND_W-1:VAL_W]),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_answer_flag  (res_flag),
    .out_sampled_value(res_value),
    .out_status       (res_status)
  );

  assign out_tdata = {7'd0, res_value, res_flag};
  assign out_tuser = res_status;

  `RSM_ASSERT_IMP(a_err_no_data, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata == '0)
  `RSM_ASSERT_IMP(a_full_empty_excl, clk, rst_n, sts.full, !sts.empty)
  `RSM_ASSERT_NXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `RSM_ASSERT_IMP(a_sample_flag_zero, clk, rst_n, cmd.cap_data, !cmd.set_flag)

endmodule

FILE: sv/rsm_ram.sv
module rsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rsm_ctrl.sv
module rsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rsm_pkg::rsm_sts_t sts,
  output rsm_pkg::rsm_cmd_t cmd
);

  import rsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_DIV,
    S_SMP_RD,
    S_SMP_CAP,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.kind)
          KIND_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt = S_OUT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          KIND_REMOVE: begin
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end
          KIND_SAMPLE: begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
              state_nxt = S_OUT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.match) begin
          state_nxt = (sts.kind == KIND_INSERT) ? S_INS_WR : S_REM_RD;
        end else if (sts.scan_end) begin
          if (sts.kind == KIND_INSERT) begin
            cmd.set_flag = 1'b1;
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_INS_WR: begin
        cmd.wr_tail = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt = S_OUT;
      end
      S_REM_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.wr_pos = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.set_flag = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_SMP_RD;
        end
      end
      S_SMP_RD: begin
        cmd.rd_rem = 1'b1;
        state_nxt = S_SMP_CAP;
      end
      S_SMP_CAP: begin
        cmd.cap_data = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/rsm_dpath.sv
module rsm_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsm_pkg::rsm_cmd_t           cmd,
  output rsm_pkg::rsm_sts_t           sts,
  input  logic [rsm_pkg::KIND_W-1:0]  in_kind,
  input  logic [rsm_pkg::VAL_W-1:0]   in_value,
  input  logic [rsm_pkg::RND_W-1:0]   in_random_word,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_answer_flag,
  output logic [rsm_pkg::VAL_W-1:0]   out_sampled_value,
  output logic [rsm_pkg::ST_W-1:0]    out_status
);

  import rsm_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KIND_W-1:0]    kind_r;
  logic [VAL_W-1:0]     value_r;
  logic [RND_W-1:0]     rnd_sh_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     scan_addr_r;
  logic                 cmp_vld_r;
  logic [ADDR_W-1:0]    cmp_addr_r;
  logic [ADDR_W-1:0]    pos_r;
  logic [CNT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 pend_flag_r;
  logic [ST_W-1:0]      pend_st_r;
  logic [VAL_W-1:0]     pend_data_r;
  logic                 out_vld_r;
  logic                 out_flag_r;
  logic [VAL_W-1:0]     out_data_r;
  logic [ST_W-1:0]      out_st_r;

  logic                 issue;
  logic                 match;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_sub;
  logic [CNT_W-1:0]     rem_nxt;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [VAL_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [VAL_W-1:0]     ram_rdata;

  assign issue = scan_addr_r < count_r;
  assign match = cmp_vld_r && (ram_rdata == value_r);
  assign cnt_m1 = count_r - CNT_W'(1);

  assign trial = {rem_r, rnd_sh_r[RND_W-1]};
  assign trial_sub = trial - {1'b0, count_r};
  assign rem_nxt = (trial >= {1'b0, count_r}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];

  always_comb begin
    sts.kind = kind_r;
    sts.full = (count_r == CNT_W'(CAPACITY));
    sts.empty = (count_r == '0);
    sts.match = match;
    sts.scan_end = !cmp_vld_r && !issue;
    sts.div_done = (div_cnt_r == DIV_CNT_W'(1));
    sts.out_free = !out_vld_r || out_ready;
  end

  always_comb begin
    ram_we = cmd.wr_tail || cmd.wr_pos;
    ram_waddr = cmd.wr_pos ? pos_r : count_r[ADDR_W-1:0];
    ram_wdata = cmd.wr_pos ? ram_rdata : value_r;
    if (cmd.rd_last) begin
      ram_raddr = cnt_m1[ADDR_W-1:0];
    end else if (cmd.rd_rem) begin
      ram_raddr = rem_r[ADDR_W-1:0];
    end else begin
      ram_raddr = scan_addr_r[ADDR_W-1:0];
    end
  end

  rsm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      value_r <= in_value;
      rnd_sh_r <= in_random_word;
      pend_flag_r <= 1'b0;
      pend_st_r <= ST_OK;
      pend_data_r <= '0;
    end else begin
      if (cmd.set_flag) begin
        pend_flag_r <= 1'b1;
      end
      if (cmd.set_full) begin
        pend_st_r <= ST_FULL;
      end else if (cmd.set_empty) begin
        pend_st_r <= ST_EMPTY;
      end
      if (cmd.cap_data) begin
        pend_data_r <= ram_rdata;
      end
      if (cmd.div_step) begin
        rnd_sh_r <= {rnd_sh_r[RND_W-2:0], 1'b0};
      end
    end

    if (cmd.scan_start) begin
      scan_addr_r <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      cmp_vld_r <= issue;
      cmp_addr_r <= scan_addr_r[ADDR_W-1:0];
      if (issue) begin
        scan_addr_r <= scan_addr_r + CNT_W'(1);
      end
      if (match) begin
        pos_r <= cmp_addr_r;
      end
    end

    if (cmd.div_start) begin
      rem_r <= '0;
      div_cnt_r <= DIV_STEPS;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end

    if (cmd.res_load) begin
      out_flag_r <= pend_flag_r;
      out_data_r <= pend_data_r;
      out_st_r <= pend_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= cnt_m1;
      end
      if (cmd.res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_answer_flag = out_flag_r;
  assign out_sampled_value = out_data_r;
  assign out_status = out_st_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rsm_pkg::*;

  localparam int CAPACITY = 64;
  localparam int LIMIT_CYCLES = 500000;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int MODE_SPAN = 90;
  localparam int TAIL_CYCLES = 100;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SEND_IDLE_PCT [4] = '{0, 66, 0, 9};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 66, 9};

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

  typedef struct packed {
    logic              flag;
    logic [VAL_W-1:0]  sampled;
    logic [ST_W-1:0]   status;
  } multiset_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [RND_W-1:0]  rnd;
    logic              pinned;
    multiset_result_t  res;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{KIND_SAMPLE, 32'h0000_0000, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_EMPTY}},
    '{KIND_REMOVE, 32'h0000_0000, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_INSERT, 32'h8000_0000, 31'h0000_0000, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_INSERT, 32'h8000_0000, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_INSERT, 32'h0000_0000, 31'h0000_0000, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_INSERT, 32'hFFFF_FFFF, 31'h0000_0000, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'hFFFF_FFFF, 31'h0000_0000, 1'b1, '{1'b0, 32'h8000_0000, ST_OK}},
    '{KIND_REMOVE, 32'h7FFF_FFFF, 31'h0000_0000, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'h0001_2345, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'h8000_0000, 31'h0000_0000, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'h0000_0000, 31'h0000_0001, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'h8000_0000, 31'h0000_0000, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'h8000_0000, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_UNUSED, 32'h0000_0000, 31'h0000_0000, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'h0000_0000, 31'h5555_5555, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'h0000_0000, 31'h0000_0000, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 31'h0000_0000, 1'b0, '{1'b0, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, ST_EMPTY}},
    '{KIND_INSERT, 32'h5A5A_5A5A, 31'h0000_0000, 1'b1, '{1'b1, 32'h0, ST_OK}},
    '{KIND_SAMPLE, 32'h0000_0000, 31'h2AAA_AAAA, 1'b1, '{1'b0, 32'h5A5A_5A5A, ST_OK}},
    '{KIND_REMOVE, 32'h5A5A_5A5A, 31'h0000_0000, 1'b0, '{1'b0, 32'h0, ST_OK}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [VAL_W-1:0] set_vals [CAPACITY];
  int               set_count = 0;
  multiset_result_t awaited_answers [$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               err_count = 0;
  int               cycle_count = 0;

  random_sample_multiset #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic multiset_result_t multiset_update(input logic [KIND_W-1:0] kind,
                                                       input logic [VAL_W-1:0] value,
                                                       input logic [RND_W-1:0] rnd);
    multiset_result_t res;
    int hit;
    res = '0;
    hit = -1;
    for (int i = set_count - 1; i >= 0; i--) begin
      if (set_vals[i] == value) hit = i;
    end
    case (kind)
      KIND_INSERT: begin
        if (set_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          res.flag = (hit < 0);
          set_vals[set_count] = value;
          set_count++;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          set_vals[hit] = set_vals[set_count - 1];
          set_count--;
          res.flag = 1'b1;
        end
      end
      KIND_SAMPLE: begin
        if (set_count == 0) res.status = ST_EMPTY;
        else res.sampled = set_vals[int'(rnd) % set_count];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                         input logic [RND_W-1:0] rnd, input logic pinned,
                         input multiset_result_t pinned_res);
    int gap;
    multiset_result_t pred;
    multiset_result_t expected_res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, rnd, value};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = multiset_update(kind, value, rnd);
    expected_res = pinned ? pinned_res : pred;
    awaited_answers = {awaited_answers, expected_res};
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (r < 45) return 32'($urandom_range(7)) - 32'd3;
    if (r < 65 && set_count > 0) return set_vals[$urandom_range(set_count - 1)];
    return $urandom();
  endfunction

  function automatic logic [RND_W-1:0] pick_rnd();
    int r;
    r = $urandom_range(99);
    if (r < 15) return RND_W'($urandom_range(130));
    if (r < 30) return 31'h7FFF_FFFF - RND_W'($urandom_range(3));
    return RND_W'($urandom() >> 1);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input mix_mode_t mode);
    int r;
    int ins_lim;
    int rem_lim;
    int smp_lim;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        ins_lim = 85; rem_lim = 90; smp_lim = 98;
      end
      MODE_SHRINK: begin
        ins_lim = 10; rem_lim = 88; smp_lim = 98;
      end
      default: begin
        ins_lim = 40; rem_lim = 70; smp_lim = 97;
      end
    endcase
    if (r < ins_lim) return KIND_INSERT;
    if (r < rem_lim) return KIND_REMOVE;
    if (r < smp_lim) return KIND_SAMPLE;
    return KIND_UNUSED;
  endfunction

  always @(posedge clk) begin
    multiset_result_t got;
    multiset_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[32:1], out_tuser};
      if (awaited_answers.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < 10)
          $display("unexpected transfer: flag %0b sampled %h status %0d",
                   got.flag, got.sampled, got.status);
      end else begin
        want = awaited_answers.pop_front();
        if (got !== want) begin
          err_count <= err_count + 1;
          if (err_count < 10)
            $display("mismatch: exp flag %0b data %h st %0d, got flag %0b data %h st %0d",
                     want.flag, want.sampled, want.status,
                     got.flag, got.sampled, got.status);
        end
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    int                rand_idx;
    rand_idx = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(DIR_TAB[i].kind, DIR_TAB[i].value, DIR_TAB[i].rnd, DIR_TAB[i].pinned,
              DIR_TAB[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = pick_kind(mix_mode_t'((rand_idx / MODE_SPAN) % 3));
        if (kind == KIND_REMOVE && set_count > 0 && $urandom_range(99) < 75)
          value = set_vals[$urandom_range(set_count - 1)];
        else
          value = pick_value();
        send_op(kind, value, pick_rnd(), 1'b0, '0);
        rand_idx++;
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && awaited_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
